>>> hw/rtl/hsm_pkg.sv
// ----------------------------------------------------------------------------
// hsm_pkg
// Shared types and constants for the handle slot map.
// ----------------------------------------------------------------------------
package hsm_pkg;

  localparam int DEPTH         = 64;
  localparam int PAYLOAD_WIDTH = 32;

  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int HANDLE_W = 6;
  localparam int DATA_W   = 32;
  localparam int LIVE_W   = 7;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_ERASE  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_WRITE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DEAD = 2'd2
  } status_e;

  typedef struct packed {
    req_e                req_type;
    logic [HANDLE_W-1:0] handle;
    logic [DATA_W-1:0]   payload_in;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle_out;
    logic [DATA_W-1:0]   payload_out;
    logic [LIVE_W-1:0]   live_entries;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic lookup;
    logic fetch;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    req_e req_type;
    logic ok;
  } sts_t;

endpackage

>>> hw/rtl/hsm_ram.sv
// ----------------------------------------------------------------------------
// hsm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hsm_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/hsm_ctrl.sv
// ----------------------------------------------------------------------------
// hsm_ctrl
// Request sequencer: lookup, payload fetch for reads, commit, result; a failed lookup goes straight to the result.
// ----------------------------------------------------------------------------
module hsm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          result_valid_o,
  input  hsm_pkg::sts_t sts_i,
  output hsm_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_FETCH,
    S_COMMIT,
    S_RESP
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE, S_RESP: begin
          done_q <= 1'b0;
          if (start) begin
            state_q <= S_LOOKUP;
            busy_q  <= 1'b1;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_LOOKUP: begin
          if (!sts_i.ok) begin
            state_q <= S_RESP;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end else if (sts_i.req_type == hsm_pkg::REQ_READ) begin
            state_q <= S_FETCH;
          end else begin
            state_q <= S_COMMIT;
          end
        end
        S_FETCH: begin
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          state_q <= S_RESP;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.latch  = start && !busy_q;
    cmd_o.lookup = (state_q == S_LOOKUP);
    cmd_o.fetch  = (state_q == S_FETCH);
    cmd_o.commit = (state_q == S_COMMIT);
  end

  assign busy           = busy_q;
  assign result_valid_o = done_q;

endmodule

>>> hw/rtl/hsm_dp.sv
// ----------------------------------------------------------------------------
// hsm_dp
// Tables, counters, live flags and result register of the slot map.
// ----------------------------------------------------------------------------
module hsm_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hsm_pkg::req_t req_i,
  input  hsm_pkg::cmd_t cmd_i,
  output hsm_pkg::sts_t sts_o,
  output hsm_pkg::rsp_t rsp_o
);

  localparam int AW = hsm_pkg::ADDR_W;
  localparam int CW = hsm_pkg::CNT_W;
  localparam int PW = hsm_pkg::PAYLOAD_WIDTH;

  hsm_pkg::req_t     req_q;
  hsm_pkg::rsp_t     rsp_q;
  logic [CW-1:0]     live_cnt_q;
  logic [CW-1:0]     free_top_q;
  logic [CW-1:0]     issued_q;
  logic [hsm_pkg::DEPTH-1:0] live_q;

  logic [AW-1:0] h_idx;
  logic [AW-1:0] live_idx;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] nh;
  logic          free_avail;
  logic          handle_ok;
  logic          ok;
  logic [CW-1:0] live_cnt_d;

  logic [AW-1:0] fh_rdata, hs_rdata, so_rdata;
  logic [PW-1:0] dp_rdata;

  logic          fh_we, hs_we, so_we, dp_we;
  logic [AW-1:0] fh_waddr, hs_waddr, so_waddr, dp_waddr;
  logic [AW-1:0] hs_wdata, so_wdata;
  logic [PW-1:0] dp_wdata;
  logic [AW-1:0] dp_raddr;
  logic          dp_re;

  assign h_idx      = AW'(req_q.handle);
  assign live_idx   = AW'(live_cnt_q);
  assign last_idx   = AW'(live_cnt_q - 1'b1);
  assign free_avail = (free_top_q != '0);
  assign nh         = free_avail ? fh_rdata : AW'(issued_q);
  assign handle_ok  = (int'(req_q.handle) < hsm_pkg::DEPTH) && live_q[h_idx];

  always_comb begin
    if (req_q.req_type == hsm_pkg::REQ_INSERT) begin
      ok = (live_cnt_q < CW'(hsm_pkg::DEPTH));
    end else begin
      ok = handle_ok;
    end
  end

  assign sts_o.req_type = req_q.req_type;
  assign sts_o.ok       = ok;

  // table write ports
  always_comb begin
    fh_we    = 1'b0;
    fh_waddr = AW'(free_top_q);
    hs_we    = 1'b0;
    hs_waddr = nh;
    hs_wdata = live_idx;
    so_we    = 1'b0;
    so_waddr = live_idx;
    so_wdata = nh;
    dp_we    = 1'b0;
    dp_waddr = live_idx;
    dp_wdata = PW'(req_q.payload_in);
    if (cmd_i.commit) begin
      case (req_q.req_type)
        hsm_pkg::REQ_INSERT: begin
          hs_we = 1'b1;
          so_we = 1'b1;
          dp_we = 1'b1;
        end
        hsm_pkg::REQ_ERASE: begin
          fh_we    = (free_top_q < CW'(hsm_pkg::DEPTH));
          hs_we    = 1'b1;
          hs_waddr = so_rdata;
          hs_wdata = hs_rdata;
          so_we    = 1'b1;
          so_waddr = hs_rdata;
          so_wdata = so_rdata;
          dp_we    = 1'b1;
          dp_waddr = hs_rdata;
          dp_wdata = dp_rdata;
        end
        hsm_pkg::REQ_WRITE: begin
          dp_we    = 1'b1;
          dp_waddr = hs_rdata;
        end
        default: begin
        end
      endcase
    end
  end

  assign dp_re    = cmd_i.lookup || cmd_i.fetch;
  assign dp_raddr = cmd_i.fetch ? hs_rdata : last_idx;

  hsm_ram #(.Width(AW), .Depth(hsm_pkg::DEPTH)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fh_we),
    .waddr_i (fh_waddr),
    .wdata_i (h_idx),
    .re_i    (cmd_i.lookup),
    .raddr_i (AW'(free_top_q - 1'b1)),
    .rdata_o (fh_rdata)
  );

  hsm_ram #(.Width(AW), .Depth(hsm_pkg::DEPTH)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (hs_we),
    .waddr_i (hs_waddr),
    .wdata_i (hs_wdata),
    .re_i    (cmd_i.lookup),
    .raddr_i (h_idx),
    .rdata_o (hs_rdata)
  );

  hsm_ram #(.Width(AW), .Depth(hsm_pkg::DEPTH)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (so_we),
    .waddr_i (so_waddr),
    .wdata_i (so_wdata),
    .re_i    (cmd_i.lookup),
    .raddr_i (last_idx),
    .rdata_o (so_rdata)
  );

  hsm_ram #(.Width(PW), .Depth(hsm_pkg::DEPTH)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dp_we),
    .waddr_i (dp_waddr),
    .wdata_i (dp_wdata),
    .re_i    (dp_re),
    .raddr_i (dp_raddr),
    .rdata_o (dp_rdata)
  );

  always_comb begin
    live_cnt_d = live_cnt_q;
    if (cmd_i.commit && req_q.req_type == hsm_pkg::REQ_INSERT) begin
      live_cnt_d = live_cnt_q + 1'b1;
    end else if (cmd_i.commit && req_q.req_type == hsm_pkg::REQ_ERASE) begin
      live_cnt_d = live_cnt_q - 1'b1;
    end
  end

  // counters and live flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_cnt_q <= '0;
      free_top_q <= '0;
      issued_q   <= '0;
      live_q     <= '0;
    end else begin
      live_cnt_q <= live_cnt_d;
      if (cmd_i.commit && req_q.req_type == hsm_pkg::REQ_INSERT) begin
        live_q[nh] <= 1'b1;
        if (free_avail) begin
          free_top_q <= free_top_q - 1'b1;
        end else begin
          issued_q <= issued_q + 1'b1;
        end
      end
      if (cmd_i.commit && req_q.req_type == hsm_pkg::REQ_ERASE) begin
        live_q[h_idx] <= 1'b0;
        if (free_top_q < CW'(hsm_pkg::DEPTH)) begin
          free_top_q <= free_top_q + 1'b1;
        end
      end
    end
  end

  // request and result words
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_i;
    end
    if (cmd_i.lookup && !ok) begin
      rsp_q.status       <= (req_q.req_type == hsm_pkg::REQ_INSERT) ?
                            hsm_pkg::ST_FULL : hsm_pkg::ST_DEAD;
      rsp_q.handle_out   <= '0;
      rsp_q.payload_out  <= '0;
      rsp_q.live_entries <= hsm_pkg::LIVE_W'(live_cnt_q);
    end else if (cmd_i.commit) begin
      rsp_q.status       <= hsm_pkg::ST_OK;
      rsp_q.handle_out   <= '0;
      rsp_q.payload_out  <= '0;
      rsp_q.live_entries <= hsm_pkg::LIVE_W'(live_cnt_d);
      if (req_q.req_type == hsm_pkg::REQ_INSERT) begin
        rsp_q.handle_out <= hsm_pkg::HANDLE_W'(nh);
      end
      if (req_q.req_type == hsm_pkg::REQ_READ) begin
        rsp_q.payload_out <= hsm_pkg::DATA_W'(dp_rdata);
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

>>> hw/rtl/handle_slot_map_core.sv
// ----------------------------------------------------------------------------
// handle_slot_map_core
// Densely packed entry table reached through stable handles, with free stack.
// Steps from accept to result strobe: lookup and commit for insert, erase
// and write; lookup, fetch and commit for read (two dependent RAM reads);
// lookup alone for a full table or dead handle. A new word is taken in the
// result cycle; none is taken while a request is in progress.
// Reset clears counters and live flags at once; the tables are not cleared.
// The receiver cannot stall: each result is shown for one cycle.
// ----------------------------------------------------------------------------
module handle_slot_map_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hsm_pkg::req_t req_i,
  output logic          result_valid_o,
  output hsm_pkg::rsp_t rsp_o
);

  hsm_pkg::cmd_t cmd;
  hsm_pkg::sts_t sts;

  hsm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  hsm_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule
